// ===== hdl/sorted_priority_queue_top_macros.svh =====
// Assertion macros for the sorted priority queue top level.
// Relies on clk and rst_n being visible at the point of use.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Condition must hold at every edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger in this cycle implies the check in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, trig, chk, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (chk)) else $error(msg);

// Trigger implies the check in the same cycle.
`define SPQ_ASSERT_SAME(lbl, trig, chk, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (chk)) else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies.
`default_nettype none
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int PRIO_W    = 8;
  localparam int OCC_W     = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins_en;
    logic   del_en;
    entry_t ent;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts right on insert,
// left on delete. Depends on spq_pkg.
`default_nettype none
module spq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire spq_pkg::cmd_t    cmd_i,
  input  wire spq_pkg::entry_t  left_i,
  input  wire logic             left_after_i,
  input  wire spq_pkg::entry_t  right_i,
  output spq_pkg::entry_t       entry_o,
  output logic                  after_o
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occ;

  // slot holds a live entry when it sits below the fill count
  assign occ     = CNT_W'(IDX) < count_i;
  // empty slots and strictly higher priorities lie behind the new entry
  assign after_o = !occ || (entry_r.prio > cmd_i.ent.prio);
  assign entry_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd_i.ins_en && after_o) begin
      entry_nxt = left_after_i ? left_i : cmd_i.ent;
    end else if (cmd_i.del_en) begin
      entry_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/sorted_priority_queue_top.sv =====
// Sorted priority queue top level: fill count, cell chain, result register.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_top_macros.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in      | input     | in_valid/in_stall  | in_opcode, in_item_data, in_item_priority
//   out     | output    | out_valid/out_stall| out_data, out_priority, out_status, out_occupancy
//
// One transaction per cycle while in_stall is low. Every accepted transaction gives its
// result in the next cycle from the output register; the chain updates in that same edge.
// The cell chain sets this rate: all slots compare against the new
// priority in parallel and shift by one place, so the next transaction sees it.
// rst_n (synchronous, active low) clears the fill count and the output valid;
// slot contents need no reset since only slots below the count are ever read.
// in_stall rises only while a result waits and out_stall holds it.
`default_nettype none
module sorted_priority_queue_top #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_opcode,
  input  wire logic signed [spq_pkg::DATA_W-1:0] in_item_data,
  input  wire logic [spq_pkg::PRIO_W-1:0]   in_item_priority,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [spq_pkg::DATA_W-1:0] out_data,
  output logic [spq_pkg::PRIO_W-1:0]        out_priority,
  output logic [1:0]                        out_status,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy
);
  import spq_pkg::*;

  `include "sorted_priority_queue_top_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);

  // fill count, 0..DEPTH
  logic [CNT_W-1:0] count_r, count_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [PRIO_W-1:0] out_prio_r, out_prio_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic   in_fire;
  logic   full, empty;
  cmd_t   cmd;
  entry_t cell_entry [DEPTH];
  logic   cell_after [DEPTH];
  logic [OCC_W+CNT_W-1:0] occ_ext;

  // a waiting result that is held blocks the input
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;

  assign cmd.ins_en   = in_fire && (in_opcode == OP_INSERT) && !full;
  assign cmd.del_en   = in_fire && (in_opcode == OP_DELETE) && !empty;
  assign cmd.ent.data = in_item_data;
  assign cmd.ent.prio = in_item_priority;

  // ---------------------------------------------------------------------------
  // Cell chain: slot 0 is the head (lowest priority, oldest among equals).
  // Insert: every slot behind the new entry takes its left neighbor, the first
  // such slot takes the new entry. Delete: each slot takes its right neighbor, the tail keeps its own.
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    entry_t left_ent;
    logic   left_aft;
    entry_t right_ent;

    if (gi == 0) begin : g_head
      assign left_ent = cmd.ent;
      assign left_aft = 1'b0;
    end else begin : g_body
      assign left_ent = cell_entry[gi-1];
      assign left_aft = cell_after[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_tail
      assign right_ent = cell_entry[gi];
    end else begin : g_mid
      assign right_ent = cell_entry[gi+1];
    end

    spq_cell #(
      .IDX   (gi),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk          (clk),
      .count_i      (count_r),
      .cmd_i        (cmd),
      .left_i       (left_ent),
      .left_after_i (left_aft),
      .right_i      (right_ent),
      .entry_o      (cell_entry[gi]),
      .after_o      (cell_after[gi])
    );
  end

  // ---------------------------------------------------------------------------
  // Count and result
  // ---------------------------------------------------------------------------
  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_prio_nxt   = out_prio_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = '0;
      out_prio_nxt   = '0;
      out_status_nxt = ST_OK;
      if (in_opcode == OP_INSERT) begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          count_nxt    = count_r - CNT_W'(1);
          out_data_nxt = cell_entry[0].data;
          out_prio_nxt = cell_entry[0].prio;
        end
      end
      out_cnt_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_prio_r   <= out_prio_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // occupancy is reported modulo 32
  assign occ_ext = {{OCC_W{1'b0}}, out_cnt_r};

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_priority  = out_prio_r;
  assign out_status    = out_status_r;
  assign out_occupancy = occ_ext[OCC_W-1:0];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "fill count above depth")
  `SPQ_ASSERT_NEXT(a_ins_count, cmd.ins_en,
                   count_r == $past(count_r) + CNT_W'(1), "insert did not grow count")
  `SPQ_ASSERT_NEXT(a_del_head, cmd.del_en,
                   out_prio_r == $past(cell_entry[0].prio), "delete returned wrong head")
  `SPQ_ASSERT_SAME(a_fail_zero, out_valid_r && (out_status_r != ST_OK),
                   out_data_r == '0 && out_prio_r == '0, "failed transaction carries payload")

endmodule
`default_nettype wire

// ===== sim/tb_sorted_priority_queue_top.sv =====
// Self-checking testbench for sorted_priority_queue_top: random insert/delete traffic
// checked against a queue-based model of the sorted store.
// Depends on spq_pkg and sorted_priority_queue_top.
`default_nettype none
module tb_sorted_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  // Worst case is far below this: ~1000 transactions with 50% idle or 50% stall per phase,
  // plus the long receiver hold-off.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int RAND_ITEMS = 950;

  // ---------------------------------------------------------------------------
  // Scoreboard: keeps its own sorted copy of the queue and the results that
  // the block still owes, oldest first.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        prio;
    status_t                  status;
    logic [OCC_W-1:0]         occ;
  } queue_result_t;

  class prio_queue_scoreboard;
    entry_t        held[$];
    queue_result_t owed[$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Work out what an accepted transaction must return and update the store.
    function void note_request(logic op, logic signed [DATA_W-1:0] data,
                               logic [PRIO_W-1:0] prio);
      queue_result_t r;
      entry_t        ent;
      int            pos;
      r.data   = '0;
      r.prio   = '0;
      r.status = ST_OK;
      if (op == OP_INSERT) begin
        if (held.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // New entry goes behind every entry of equal or lower priority.
          pos = 0;
          while (pos < held.size() && held[pos].prio <= prio) pos++;
          ent.data = data;
          ent.prio = prio;
          held.insert(pos, ent);
        end
      end else begin
        if (held.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = held[0].data;
          r.prio = held[0].prio;
          void'(held.pop_front());
        end
      end
      r.occ = OCC_W'(held.size());
      owed.push_back(r);
    endfunction

    function void cmp_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic signed [DATA_W-1:0] data, logic [PRIO_W-1:0] prio,
                               logic [1:0] status, logic [OCC_W-1:0] occ);
      queue_result_t r;
      if (owed.size() == 0) begin
        $display("%0t: result with none owed, expected none actual data %0d prio %0d",
                 $time, data, prio);
        errors++;
      end else begin
        r = owed.pop_front();
        cmp_field("out_data", r.data, data);
        cmp_field("out_priority", r.prio, prio);
        cmp_field("out_status", r.status, status);
        cmp_field("out_occupancy", r.occ, occ);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid         = 1'b0;
  logic                      in_opcode        = OP_INSERT;
  logic signed [DATA_W-1:0]  in_item_data     = '0;
  logic [PRIO_W-1:0]         in_item_priority = '0;
  logic                      out_stall        = 1'b0;

  logic                      in_stall;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_data;
  logic [PRIO_W-1:0]         out_priority;
  logic [1:0]                out_status;
  logic [OCC_W-1:0]          out_occupancy;

  always #10 clk = ~clk;

  sorted_priority_queue_top #(.DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_item_data     (in_item_data),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .out_priority     (out_priority),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

  prio_queue_scoreboard sb;

  // Knobs for the current phase; read by the driver and the stall process.
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_ask  = 0;   // bumped by the main sequence to request a long hold-off

  // ---------------------------------------------------------------------------
  // Receiver: random stall per phase, plus a long hold-off on request. The
  // hold-off is counted here so the sender keeps offering meanwhile and the
  // block backs up into in_stall.
  // ---------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the edge, before this edge's updates land.
  // A result can never belong to a transaction accepted at the same edge, so
  // the result is checked before the new transaction is noted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_data, out_priority, out_status, out_occupancy);
      if (in_valid && !in_stall)
        sb.note_request(in_opcode, in_item_data, in_item_priority);
    end
  end

  // Watchdog.
  int cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: optional random idle gap, then hold the transaction until taken.
  // Called at a rising edge; returns at the edge where the transaction is accepted.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic signed [DATA_W-1:0] data,
                           input logic [PRIO_W-1:0] prio);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_item_data     <= data;
    in_item_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random traffic. The insert bias moves in blocks so the queue regularly
  // runs full and runs dry; priorities are often packed into a tiny range so
  // ties (arrival order) get exercised.
  task automatic run_random(input int count, input int idle, input int stall);
    int   bias;
    logic op;
    logic [PRIO_W-1:0] prio;
    idle_pct  = idle;
    stall_pct = stall;
    bias      = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       bias = 15;
          1:       bias = 50;
          default: bias = 85;
        endcase
      end
      op   = ($urandom_range(99) < bias) ? OP_INSERT : OP_DELETE;
      prio = $urandom_range(1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom_range(255));
      send_item(op, $urandom, prio);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty delete, extremes, ties, fill to full, full insert, partial drain.
    send_item(OP_DELETE, $urandom, PRIO_W'($urandom));
    send_item(OP_INSERT, 32'sh8000_0000, 8'd255);
    send_item(OP_INSERT, 32'sh7FFF_FFFF, 8'd0);
    send_item(OP_INSERT, -32'sd1, 8'd128);
    send_item(OP_INSERT, 32'sd0, 8'd0);          // tie at priority 0, must follow
    for (int i = 0; i < DEPTH - 4; i++)
      send_item(OP_INSERT, $urandom, (i % 3 == 0) ? 8'd7 : PRIO_W'(i * 21));
    send_item(OP_INSERT, 32'sd5, 8'd0);          // queue full: dropped
    for (int i = 0; i < 6; i++)
      send_item(OP_DELETE, $urandom, PRIO_W'($urandom));

    // Phase with no idling; starts with the long receiver hold-off.
    hold_ask = hold_ask + 1;
    run_random(RAND_ITEMS / 4, 0, 0);
    run_random(RAND_ITEMS / 4, 50, 0);
    run_random(RAND_ITEMS / 4, 0, 50);
    run_random(RAND_ITEMS - 3 * (RAND_ITEMS / 4), 25, 25);

    // drop in_valid, then wait until every owed result has come out
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
